[rtl/assert_macros.svh]
// Assertion macros used by the port-level checker, mtbe_chk.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is low
`define MTBE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// clocked property, checked during reset as well
`define MTBE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/mtbe_pkg.sv]
// Types and constants of the MPPC token bit packer.
// No dependencies; used by every module of the block but the checker.
package mtbe_pkg;

    localparam int CODE_W     = 49;  // longest token code: 3+16 offset, 15+15 length
    localparam int NBITS_W    = 6;
    localparam int ACC_W      = 56;  // 7 pending bits + longest code
    localparam int OFF_CODE_W = 19;
    localparam int LEN_CODE_W = 30;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [15:0] OFF_SMALL_LIM = 16'd64;
    localparam logic [15:0] OFF_MID_LIM   = 16'd320;
    localparam logic [15:0] OFF_8K_LIM    = 16'd8192;
    localparam logic [15:0] OFF_WIDE_LIM  = 16'd2368;
    localparam logic [15:0] LEN_MIN       = 16'd3;
    localparam logic [15:0] LEN_8K_MAX    = 16'd8191;
    localparam logic [7:0]  LIT_WIDE_MIN  = 8'h80;

    localparam logic [3:0] PFX8_SMALL  = 4'hF;
    localparam logic [3:0] PFX8_MID    = 4'hE;
    localparam logic [2:0] PFX8_LARGE  = 3'h6;
    localparam logic [4:0] PFX64_SMALL = 5'h1F;
    localparam logic [4:0] PFX64_MID   = 5'h1E;
    localparam logic [3:0] PFX64_WIDE  = 4'hE;
    localparam logic [2:0] PFX64_LARGE = 3'h6;
    localparam logic [1:0] PFX_LIT_HI  = 2'b10;

    typedef enum logic [1:0] {
        REQ_LITERAL = 2'd0,
        REQ_COPY    = 2'd1,
        REQ_FLUSH   = 2'd2,
        REQ_UNUSED  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        TOK_CODE  = 2'd0,
        TOK_BAD   = 2'd1,
        TOK_FLUSH = 2'd2
    } t_tok_kind;

    // code is left-aligned; bits below nbits are zero
    typedef struct packed {
        t_tok_kind           kind;
        logic [CODE_W-1:0]   code;
        logic [NBITS_W-1:0]  nbits;
    } t_tok;

endpackage

[rtl/mtbe_front.sv]
// Front end: holds the history-mode register, classifies tokens and builds their codes.
// Depends on mtbe_pkg.
module mtbe_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_push,
    input  logic                i_q_full,
    input  logic [1:0]          i_req_type,
    input  logic [7:0]          i_literal_byte,
    input  logic [15:0]         i_match_dist,
    input  logic [15:0]         i_match_len,
    output logic                o_wr,
    output mtbe_pkg::t_tok      o_tok
);

    logic        r_dict_mode;
    logic        n_dict_mode;

    logic [mtbe_pkg::OFF_CODE_W-1:0] ocode;
    logic [4:0]  olen;
    logic        off_ok;
    logic [15:0] off_m64;
    logic [15:0] off_m320;
    logic [15:0] off_m2368;

    logic [3:0]  len_k;
    logic [mtbe_pkg::LEN_CODE_W-1:0] lpre;
    logic [mtbe_pkg::LEN_CODE_W-1:0] lmask;
    logic [mtbe_pkg::LEN_CODE_W-1:0] lbody;
    logic [mtbe_pkg::LEN_CODE_W-1:0] lcode;
    logic [4:0]  llen;
    logic        len_ok;

    logic [mtbe_pkg::CODE_W-1:0] copy_code;
    logic [mtbe_pkg::CODE_W-1:0] lit_code;
    logic [mtbe_pkg::NBITS_W-1:0] lit_nbits;

    always_comb begin
        n_dict_mode = r_dict_mode;
        if (i_cfg_we) begin
            n_dict_mode = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dict_mode <= 1'b0;
        end else begin
            r_dict_mode <= n_dict_mode;
        end
    end

    assign off_m64   = i_match_dist - mtbe_pkg::OFF_SMALL_LIM;
    assign off_m320  = i_match_dist - mtbe_pkg::OFF_MID_LIM;
    assign off_m2368 = i_match_dist - mtbe_pkg::OFF_WIDE_LIM;

    // offset class: prefix plus biased offset, left-aligned
    always_comb begin
        ocode  = '0;
        olen   = 5'd0;
        off_ok = 1'b1;
        if (!r_dict_mode) begin
            if (i_match_dist < mtbe_pkg::OFF_SMALL_LIM) begin
                ocode = {mtbe_pkg::PFX8_SMALL, i_match_dist[5:0], 9'd0};
                olen  = 5'd10;
            end else if (i_match_dist < mtbe_pkg::OFF_MID_LIM) begin
                ocode = {mtbe_pkg::PFX8_MID, off_m64[7:0], 7'd0};
                olen  = 5'd12;
            end else if (i_match_dist < mtbe_pkg::OFF_8K_LIM) begin
                ocode = {mtbe_pkg::PFX8_LARGE, off_m320[12:0], 3'd0};
                olen  = 5'd16;
            end else begin
                off_ok = 1'b0;
            end
        end else begin
            if (i_match_dist < mtbe_pkg::OFF_SMALL_LIM) begin
                ocode = {mtbe_pkg::PFX64_SMALL, i_match_dist[5:0], 8'd0};
                olen  = 5'd11;
            end else if (i_match_dist < mtbe_pkg::OFF_MID_LIM) begin
                ocode = {mtbe_pkg::PFX64_MID, off_m64[7:0], 6'd0};
                olen  = 5'd13;
            end else if (i_match_dist < mtbe_pkg::OFF_WIDE_LIM) begin
                ocode = {mtbe_pkg::PFX64_WIDE, off_m320[10:0], 4'd0};
                olen  = 5'd15;
            end else begin
                ocode = {mtbe_pkg::PFX64_LARGE, off_m2368};
                olen  = 5'd19;
            end
        end
    end

    // length class k = position of the leading one
    always_comb begin
        len_k = 4'd2;
        for (int i = 2; i < 16; i++) begin
            if (i_match_len[i]) begin
                len_k = 4'(i);
            end
        end
    end

    always_comb begin
        lpre  = (mtbe_pkg::LEN_CODE_W'(1) << len_k) - mtbe_pkg::LEN_CODE_W'(2);
        lmask = (mtbe_pkg::LEN_CODE_W'(1) << len_k) - mtbe_pkg::LEN_CODE_W'(1);
        lbody = (lpre << len_k)
              | ({{(mtbe_pkg::LEN_CODE_W-16){1'b0}}, i_match_len} & lmask);
        if (i_match_len == mtbe_pkg::LEN_MIN) begin
            lcode = '0;
            llen  = 5'd1;
        end else begin
            llen  = {len_k, 1'b0};
            lcode = lbody << (5'(mtbe_pkg::LEN_CODE_W) - llen);
        end
        len_ok = (i_match_len >= mtbe_pkg::LEN_MIN)
              && (r_dict_mode || (i_match_len <= mtbe_pkg::LEN_8K_MAX));
    end

    assign copy_code = {ocode, {mtbe_pkg::LEN_CODE_W{1'b0}}}
                     | ({lcode, {mtbe_pkg::OFF_CODE_W{1'b0}}} >> olen);

    always_comb begin
        if (i_literal_byte < mtbe_pkg::LIT_WIDE_MIN) begin
            lit_code  = {i_literal_byte, {(mtbe_pkg::CODE_W-8){1'b0}}};
            lit_nbits = mtbe_pkg::NBITS_W'(8);
        end else begin
            lit_code  = {mtbe_pkg::PFX_LIT_HI, i_literal_byte[6:0],
                         {(mtbe_pkg::CODE_W-9){1'b0}}};
            lit_nbits = mtbe_pkg::NBITS_W'(9);
        end
    end

    always_comb begin
        o_wr        = i_push && !i_q_full;
        o_tok.kind  = mtbe_pkg::TOK_CODE;
        o_tok.code  = '0;
        o_tok.nbits = '0;
        case (mtbe_pkg::t_req'(i_req_type))
            mtbe_pkg::REQ_LITERAL: begin
                o_tok.code  = lit_code;
                o_tok.nbits = lit_nbits;
            end
            mtbe_pkg::REQ_COPY: begin
                if (off_ok && len_ok) begin
                    o_tok.code  = copy_code;
                    o_tok.nbits = {1'b0, olen} + {1'b0, llen};
                end else begin
                    o_tok.kind = mtbe_pkg::TOK_BAD;
                end
            end
            mtbe_pkg::REQ_FLUSH: begin
                o_tok.kind = mtbe_pkg::TOK_FLUSH;
            end
            default: begin
                o_wr = 1'b0;  // unused code is taken and dropped
            end
        endcase
    end

endmodule

[rtl/mtbe_queue.sv]
// Short token queue between front and back end.
// Depends on mtbe_pkg. DEPTH must be a power of two, at least 2.
module mtbe_queue #(
    parameter int DEPTH = mtbe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  mtbe_pkg::t_tok  i_tok,
    output logic            o_full,
    input  logic            i_rd,
    output mtbe_pkg::t_tok  o_tok,
    output logic            o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    mtbe_pkg::t_tok r_mem [DEPTH];
    logic [AW-1:0]  r_wptr, n_wptr;
    logic [AW-1:0]  r_rptr, n_rptr;
    logic [CW-1:0]  r_count, n_count;
    logic           do_wr, do_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_tok   = r_mem[r_rptr];

    always_comb begin
        n_wptr  = do_wr ? r_wptr + AW'(1) : r_wptr;
        n_rptr  = do_rd ? r_rptr + AW'(1) : r_rptr;
        n_count = r_count;
        if (do_wr && !do_rd) begin
            n_count = r_count + CW'(1);
        end else if (!do_wr && do_rd) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_tok;
        end
    end

endmodule

[rtl/mtbe_back.sv]
// Back end: bit accumulator, byte emission and the result register.
// Depends on mtbe_pkg.
module mtbe_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  mtbe_pkg::t_tok  i_tok,
    output logic            o_q_rd,
    input  logic            i_pop,
    output logic            o_empty,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_valid,
    output logic            o_is_last,
    output logic            o_bad_token
);

    localparam int AW = mtbe_pkg::ACC_W;

    // pending bits sit at the top of r_acc; everything below them is zero
    logic [AW-1:0]                r_acc, n_acc;
    logic [mtbe_pkg::NBITS_W-1:0] r_len, n_len;
    logic       r_ov, n_ov;
    logic [7:0] r_obyte, n_obyte;
    logic       r_ovb, n_ovb;
    logic       r_olast, n_olast;
    logic       r_obad, n_obad;
    logic       slot_free;
    logic       load;

    assign slot_free = !r_ov || i_pop;

    always_comb begin
        n_acc   = r_acc;
        n_len   = r_len;
        n_obyte = r_obyte;
        n_ovb   = r_ovb;
        n_olast = r_olast;
        n_obad  = r_obad;
        o_q_rd  = 1'b0;
        load    = 1'b0;
        if (r_len >= mtbe_pkg::NBITS_W'(8)) begin
            if (slot_free) begin
                load    = 1'b1;
                n_obyte = r_acc[AW-1 -: 8];
                n_ovb   = 1'b1;
                n_olast = 1'b0;
                n_obad  = 1'b0;
                n_acc   = r_acc << 8;
                n_len   = r_len - mtbe_pkg::NBITS_W'(8);
            end
        end else if (!i_q_empty) begin
            case (i_tok.kind)
                mtbe_pkg::TOK_CODE: begin
                    o_q_rd = 1'b1;
                    n_acc  = r_acc | ({i_tok.code, 7'd0} >> r_len);
                    n_len  = r_len + i_tok.nbits;
                end
                mtbe_pkg::TOK_BAD: begin
                    if (slot_free) begin
                        o_q_rd  = 1'b1;
                        load    = 1'b1;
                        n_obyte = 8'd0;
                        n_ovb   = 1'b0;
                        n_olast = 1'b0;
                        n_obad  = 1'b1;
                    end
                end
                mtbe_pkg::TOK_FLUSH: begin
                    if (slot_free) begin
                        o_q_rd  = 1'b1;
                        load    = 1'b1;
                        n_obyte = r_acc[AW-1 -: 8];  // zero padded by invariant
                        n_ovb   = (r_len != '0);
                        n_olast = 1'b1;
                        n_obad  = 1'b0;
                        n_acc   = '0;
                        n_len   = '0;
                    end
                end
                default: begin
                    o_q_rd = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        n_ov = r_ov;
        if (load) begin
            n_ov = 1'b1;
        end else if (i_pop) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_len <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_acc <= n_acc;
            r_len <= n_len;
            r_ov  <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_obyte <= n_obyte;
        r_ovb   <= n_ovb;
        r_olast <= n_olast;
        r_obad  <= n_obad;
    end

    assign o_empty      = !r_ov;
    assign o_out_byte   = r_obyte;
    assign o_byte_valid = r_ovb;
    assign o_is_last    = r_olast;
    assign o_bad_token  = r_obad;

endmodule

[rtl/mppc_token_bitstream_encoder_top.sv]
// Top level of the MPPC token bit packer.
// Depends on mtbe_pkg, mtbe_front, mtbe_queue and mtbe_back.

// MPPC (RFC 2118) token bit packer, 8K or 64K history codes chosen by the
// one-bit register written through i_cfg_we/i_cfg_wdata. The input side
// takes one token per cycle until the token queue (QUEUE_DEPTH entries) is
// full. The back end merges one queued token per cycle into its bit
// accumulator and then sends one byte per cycle into the result register
// while that register is empty or being popped. Rejected copies and
// flushes give one result each. The result register refills in the cycle
// it is popped. No clearing pass after reset.
module mppc_token_bitstream_encoder_top #(
    parameter int QUEUE_DEPTH = mtbe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_literal_byte,
    input  logic [15:0] i_match_dist,
    input  logic [15:0] i_match_len,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_is_last,
    output logic        o_bad_token
);

    logic           q_wr;
    logic           q_rd;
    logic           q_empty;
    mtbe_pkg::t_tok front_tok;
    mtbe_pkg::t_tok back_tok;

    mtbe_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_push         (push),
        .i_q_full       (full),
        .i_req_type     (i_req_type),
        .i_literal_byte (i_literal_byte),
        .i_match_dist   (i_match_dist),
        .i_match_len    (i_match_len),
        .o_wr           (q_wr),
        .o_tok          (front_tok)
    );

    mtbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_tok   (front_tok),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_tok   (back_tok),
        .o_empty (q_empty)
    );

    mtbe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_tok        (back_tok),
        .o_q_rd       (q_rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_is_last    (o_is_last),
        .o_bad_token  (o_bad_token)
    );

endmodule

[rtl/mtbe_chk.sv]
// Port-level checker for the MPPC token bit packer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module mtbe_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_byte,
    input logic       o_byte_valid,
    input logic       o_is_last,
    input logic       o_bad_token
);

    `MTBE_ASSERT(a_hold_result, i_clk, i_rst_n, !empty && !pop |=> !empty && $stable(o_out_byte), "result changed while not popped")
    `MTBE_ASSERT(a_last_not_bad, i_clk, i_rst_n, !empty |-> !(o_is_last && o_bad_token), "item both last and bad")
    `MTBE_ASSERT(a_bad_is_blank, i_clk, i_rst_n, !empty && o_bad_token |-> !o_byte_valid && (o_out_byte == 8'd0), "bad item carries data")
    `MTBE_ASSERT(a_marker_kind, i_clk, i_rst_n, !empty && !o_byte_valid |-> o_is_last || o_bad_token, "dataless item is neither last nor bad")
    `MTBE_ASSERT_ALWAYS(a_reset_idle, i_clk, $rose(i_rst_n) |-> empty && !full, "not idle after reset")

endmodule

bind mppc_token_bitstream_encoder_top mtbe_chk u_mtbe_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_out_byte   (o_out_byte),
    .o_byte_valid (o_byte_valid),
    .o_is_last    (o_is_last),
    .o_bad_token  (o_bad_token)
);

[bench/mtbe_checker.sv]
// Scoreboard for the MPPC token bit packer: watches the token and byte queues,
// predicts the packed byte stream and compares it. Depends on mtbe_pkg.
module mtbe_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_literal_byte,
    input  logic [15:0] i_match_dist,
    input  logic [15:0] i_match_len,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [7:0]  i_out_byte,
    input  logic        i_byte_valid,
    input  logic        i_is_last,
    input  logic        i_bad_token,
    output int          o_fails,
    output int          o_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       last;
        logic       rejected;
    } t_out_item;

    t_out_item   bytes_due[$];
    logic        wide_hist;    // 64K codes when set
    logic [6:0]  carry_bits;
    logic [2:0]  carry_cnt;
    logic [63:0] acc;
    int          acc_len;
    int          fails;

    task automatic add_bits(input logic [31:0] val, input int n);
        logic [63:0] mask;
        mask = (64'd1 << n) - 64'd1;
        acc = (acc << n) | ({32'd0, val} & mask);
        acc_len += n;
    endtask

    task automatic due_item(input logic [7:0] data, input logic has_data,
                            input logic last, input logic rejected);
        t_out_item it;
        it.data = data;
        it.has_data = has_data;
        it.last = last;
        it.rejected = rejected;
        bytes_due.push_back(it);
    endtask

    // bits of a copy go into acc; ok is cleared when the token is out of range
    task automatic code_copy(input logic [15:0] off, input logic [15:0] len,
                             output bit ok);
        int k;
        ok = 1'b1;
        if (!wide_hist) begin
            if (off < mtbe_pkg::OFF_SMALL_LIM) begin
                add_bits(mtbe_pkg::PFX8_SMALL, 4);
                add_bits(off, 6);
            end else if (off < mtbe_pkg::OFF_MID_LIM) begin
                add_bits(mtbe_pkg::PFX8_MID, 4);
                add_bits(off - mtbe_pkg::OFF_SMALL_LIM, 8);
            end else if (off < mtbe_pkg::OFF_8K_LIM) begin
                add_bits(mtbe_pkg::PFX8_LARGE, 3);
                add_bits(off - mtbe_pkg::OFF_MID_LIM, 13);
            end else begin
                ok = 1'b0;
            end
        end else begin
            if (off < mtbe_pkg::OFF_SMALL_LIM) begin
                add_bits(mtbe_pkg::PFX64_SMALL, 5);
                add_bits(off, 6);
            end else if (off < mtbe_pkg::OFF_MID_LIM) begin
                add_bits(mtbe_pkg::PFX64_MID, 5);
                add_bits(off - mtbe_pkg::OFF_SMALL_LIM, 8);
            end else if (off < mtbe_pkg::OFF_WIDE_LIM) begin
                add_bits(mtbe_pkg::PFX64_WIDE, 4);
                add_bits(off - mtbe_pkg::OFF_MID_LIM, 11);
            end else begin
                add_bits(mtbe_pkg::PFX64_LARGE, 3);
                add_bits(off - mtbe_pkg::OFF_WIDE_LIM, 16);
            end
        end
        if (len < mtbe_pkg::LEN_MIN) begin
            ok = 1'b0;
        end else if (len == mtbe_pkg::LEN_MIN) begin
            add_bits(32'd0, 1);
        end else begin
            k = 2;
            while (k < 15 && len >= (32'd1 << (k + 1))) k++;
            if (!wide_hist && k > 12) begin
                ok = 1'b0;
            end else begin
                add_bits(((32'd1 << k) - 32'd1) & ~32'd1, k);
                add_bits(len, k);
            end
        end
    endtask

    task automatic pack_token(input logic [1:0] req, input logic [7:0] lit,
                              input logic [15:0] off, input logic [15:0] len);
        bit          ok;
        logic [63:0] sh;
        logic [7:0]  keep;
        acc = {57'd0, carry_bits};
        acc_len = carry_cnt;
        if (req == mtbe_pkg::REQ_FLUSH) begin
            if (acc_len == 0) begin
                due_item(8'h00, 1'b0, 1'b1, 1'b0);
            end else begin
                sh = acc << (8 - acc_len);
                due_item(sh[7:0], 1'b1, 1'b1, 1'b0);
            end
            carry_bits = '0;
            carry_cnt = '0;
        end else if (req != mtbe_pkg::REQ_UNUSED) begin
            ok = 1'b1;
            if (req == mtbe_pkg::REQ_LITERAL) begin
                if (lit < mtbe_pkg::LIT_WIDE_MIN) begin
                    add_bits(lit, 8);
                end else begin
                    add_bits(mtbe_pkg::PFX_LIT_HI, 2);
                    add_bits(lit, 7);
                end
            end else begin
                code_copy(off, len, ok);
            end
            if (!ok) begin
                due_item(8'h00, 1'b0, 1'b0, 1'b1);
            end else begin
                while (acc_len >= 8) begin
                    sh = acc >> (acc_len - 8);
                    due_item(sh[7:0], 1'b1, 1'b0, 1'b0);
                    acc_len -= 8;
                end
                keep = (8'd1 << acc_len) - 8'd1;
                carry_cnt = acc_len[2:0];
                carry_bits = acc[6:0] & keep[6:0];
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (!i_rst_n) begin
            wide_hist = 1'b0;
            carry_bits = '0;
            carry_cnt = '0;
            bytes_due.delete();
        end else begin
            if (i_cfg_we)
                wide_hist = i_cfg_wdata;
            if (i_pop && !i_empty) begin
                got.data = i_out_byte;
                got.has_data = i_byte_valid;
                got.last = i_is_last;
                got.rejected = i_bad_token;
                if (bytes_due.size() == 0) begin
                    $display("%0t: item with none expected: data=%02h valid=%0b last=%0b bad=%0b",
                             $time, got.data, got.has_data, got.last, got.rejected);
                    fails++;
                end else begin
                    want = bytes_due.pop_front();
                    if (got.data !== want.data || got.has_data !== want.has_data ||
                        got.last !== want.last || got.rejected !== want.rejected) begin
                        $display("%0t: mismatch: expected data=%02h valid=%0b last=%0b bad=%0b",
                                 $time, want.data, want.has_data, want.last, want.rejected);
                        $display("%0t:           actual   data=%02h valid=%0b last=%0b bad=%0b",
                                 $time, got.data, got.has_data, got.last, got.rejected);
                        fails++;
                    end
                end
            end
            if (i_push && !i_full)
                pack_token(i_req_type, i_literal_byte, i_match_dist, i_match_len);
        end
        o_fails = fails;
        o_waiting = bytes_due.size();
    end

endmodule

[bench/tb.sv]
// Top of the MPPC token bit packer bench: clock, reset, token stimulus and verdict.
// Depends on mtbe_pkg, mtbe_checker and the mppc_token_bitstream_encoder_top RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STUCK_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 80;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  req_type = mtbe_pkg::REQ_LITERAL;
    logic [7:0]  literal_byte = '0;
    logic [15:0] match_dist = '0;
    logic [15:0] match_len = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        is_last;
    logic        bad_token;

    int n_fails;
    int n_waiting;
    int stuck_cycles = 0;
    bit steady = 1'b0;   // no idling on either side while set
    bit wide = 1'b0;     // mode as last written

    mppc_token_bitstream_encoder_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .push           (push),
        .full           (full),
        .i_req_type     (req_type),
        .i_literal_byte (literal_byte),
        .i_match_dist   (match_dist),
        .i_match_len    (match_len),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (out_byte),
        .o_byte_valid   (byte_valid),
        .o_is_last      (is_last),
        .o_bad_token    (bad_token)
    );

    mtbe_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_push         (push),
        .i_full         (full),
        .i_req_type     (req_type),
        .i_literal_byte (literal_byte),
        .i_match_dist   (match_dist),
        .i_match_len    (match_len),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_out_byte     (out_byte),
        .i_byte_valid   (byte_valid),
        .i_is_last      (is_last),
        .i_bad_token    (bad_token),
        .o_fails        (n_fails),
        .o_waiting      (n_waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        pop <= steady || ($urandom_range(99) >= 6);
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // push stays high after acceptance; a mode change, or an idle spell in the next call, lowers it
    task automatic send_token(input logic [1:0] req, input logic [7:0] lit,
                              input logic [15:0] off, input logic [15:0] len);
        if (!steady) begin
            while ($urandom_range(99) < 6) begin
                push <= 1'b0;
                @(posedge i_clk);
            end
        end
        push <= 1'b1;
        req_type <= req;
        literal_byte <= lit;
        match_dist <= off;
        match_len <= len;
        do @(posedge i_clk); while (full);
    endtask

    task automatic set_mode(input bit m);
        push <= 1'b0;
        @(posedge i_clk);
        while (n_waiting != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        wide = m;
    endtask

    task automatic random_copy_len(output logic [15:0] len);
        int k;
        int q;
        q = $urandom_range(99);
        if (q < 30) begin
            len = mtbe_pkg::LEN_MIN;
        end else begin
            if (q < 90)
                k = $urandom_range(7, 2);
            else
                k = $urandom_range(wide ? 15 : 12, 8);
            len = $urandom_range((1 << (k + 1)) - 1, 1 << k);
        end
    endtask

    // returns 0 for a token the block ignores
    task automatic random_token(output bit counts);
        logic [1:0]  req;
        logic [7:0]  lit;
        logic [15:0] off;
        logic [15:0] len;
        int p;
        lit = $urandom_range(255);
        off = $urandom_range(65535);
        len = $urandom_range(65535);
        counts = 1'b1;
        p = $urandom_range(99);
        if (p < 45) begin
            req = mtbe_pkg::REQ_LITERAL;
        end else if (p < 88) begin
            req = mtbe_pkg::REQ_COPY;
            case ($urandom_range(3))
                0: off = $urandom_range(mtbe_pkg::OFF_SMALL_LIM - 1);
                1: off = $urandom_range(mtbe_pkg::OFF_MID_LIM - 1, mtbe_pkg::OFF_SMALL_LIM);
                2: off = $urandom_range(mtbe_pkg::OFF_WIDE_LIM - 1, mtbe_pkg::OFF_MID_LIM);
                default: off = $urandom_range(wide ? 65535 : mtbe_pkg::OFF_8K_LIM - 1,
                                              mtbe_pkg::OFF_WIDE_LIM);
            endcase
            random_copy_len(len);
        end else if (p < 93) begin
            // out-of-range copy
            req = mtbe_pkg::REQ_COPY;
            case ($urandom_range(2))
                0: len = $urandom_range(mtbe_pkg::LEN_MIN - 1);
                1: if (!wide) off = $urandom_range(65535, mtbe_pkg::OFF_8K_LIM);
                   else len = $urandom_range(mtbe_pkg::LEN_MIN - 1);
                default: if (!wide) len = $urandom_range(65535, mtbe_pkg::LEN_8K_MAX + 1);
                         else len = $urandom_range(mtbe_pkg::LEN_MIN - 1);
            endcase
        end else if (p < 97) begin
            req = mtbe_pkg::REQ_FLUSH;
        end else begin
            req = mtbe_pkg::REQ_UNUSED;
            counts = 1'b0;
        end
        send_token(req, lit, off, len);
    endtask

    initial begin
        bit counts;
        int done;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 8K codes: literal edges, every offset class, length edges, rejects
        set_mode(1'b0);
        send_token(mtbe_pkg::REQ_FLUSH,   8'h00, 16'd0,    16'd0);     // flush, nothing held
        send_token(mtbe_pkg::REQ_LITERAL, 8'h00, 16'd0,    16'd0);
        send_token(mtbe_pkg::REQ_LITERAL, 8'h7F, 16'hFFFF, 16'hFFFF);
        send_token(mtbe_pkg::REQ_LITERAL, 8'h80, 16'd0,    16'd0);
        send_token(mtbe_pkg::REQ_LITERAL, 8'hFF, 16'd0,    16'd0);
        send_token(mtbe_pkg::REQ_COPY,    8'h00, 16'd0,    16'd3);     // offset zero
        send_token(mtbe_pkg::REQ_COPY,    8'h00, 16'd63,   16'd4);
        send_token(mtbe_pkg::REQ_COPY,    8'h00, 16'd64,   16'd7);
        send_token(mtbe_pkg::REQ_COPY,    8'h00, 16'd319,  16'd8);
        send_token(mtbe_pkg::REQ_COPY,    8'h00, 16'd320,  16'd255);
        send_token(mtbe_pkg::REQ_COPY,    8'h00, 16'd8191, 16'd8191);
        send_token(mtbe_pkg::REQ_COPY,    8'h00, 16'd8192, 16'd3);     // offset too far
        send_token(mtbe_pkg::REQ_COPY,    8'h00, 16'd5,    16'd2);     // too short
        send_token(mtbe_pkg::REQ_COPY,    8'h00, 16'd5,    16'd8192);  // too long for 8K
        send_token(mtbe_pkg::REQ_COPY,    8'h00, 16'd0,    16'd0);
        send_token(mtbe_pkg::REQ_UNUSED,  8'hFF, 16'hFFFF, 16'hFFFF);
        send_token(mtbe_pkg::REQ_FLUSH,   8'h00, 16'd0,    16'd0);     // flush with bits held
        send_token(mtbe_pkg::REQ_FLUSH,   8'h00, 16'd0,    16'd0);

        // 64K codes
        set_mode(1'b1);
        send_token(mtbe_pkg::REQ_LITERAL, 8'hA5, 16'd0,     16'd0);
        send_token(mtbe_pkg::REQ_COPY,    8'h00, 16'd2367,  16'd16);
        send_token(mtbe_pkg::REQ_COPY,    8'h00, 16'd2368,  16'd65535);
        send_token(mtbe_pkg::REQ_COPY,    8'h00, 16'd65535, 16'd32768);
        send_token(mtbe_pkg::REQ_COPY,    8'h00, 16'd100,   16'd8192);
        send_token(mtbe_pkg::REQ_COPY,    8'h00, 16'd65535, 16'd2);
        send_token(mtbe_pkg::REQ_FLUSH,   8'h00, 16'd0,     16'd0);

        for (int ph = 0; ph < 6; ph++) begin
            set_mode(ph[0] ? 1'b0 : 1'b1);
            steady = (ph == 2);
            done = 0;
            while (done < PHASE_ITEMS) begin
                random_token(counts);
                if (counts)
                    done++;
            end
        end
        steady = 1'b0;

        push <= 1'b0;
        @(posedge i_clk);
        while (n_waiting != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
